// ----- hw/rtl/hppa_pkg.sv -----
// Shared types, operation codes and default sizes for the hashed process page allocator.
package hppa_pkg;

  localparam int unsigned MEMORY_WORDS_DEF = 4096;
  localparam int unsigned PAGE_WORDS_DEF   = 64;

  localparam int unsigned MOD_STEPS = 2;
  localparam int unsigned CNT_W     = $clog2(MOD_STEPS);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_SEARCH = 3'd1,
    OP_WRITE  = 3'd2,
    OP_READ   = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  typedef struct packed {
    logic             capture;
    logic             match;
    logic             encode;
    logic             exec;
    logic             mod_step;
    logic [CNT_W-1:0] mod_phase;
    logic             resp_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_mod;
    logic out_free;
  } ctl_sts_t;

endpackage

// ----- hw/rtl/hppa_in_if.sv -----
// Request channel carrying one operation transaction.
interface hppa_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [31:0]        pid;
  logic [31:0]        offset;
  logic signed [31:0] value;

  modport source (output valid, operation, pid, offset, value, input ready);
  modport sink (input valid, operation, pid, offset, value, output ready);
endinterface

// ----- hw/rtl/hppa_out_if.sv -----
// Response channel carrying one result transaction.
interface hppa_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [5:0]         bucket;
  logic [31:0]        offset_echo;
  logic signed [31:0] read_value;

  modport source (output valid, status, bucket, offset_echo, read_value, input ready);
  modport sink (input valid, status, bucket, offset_echo, read_value, output ready);
endinterface

// ----- hw/rtl/hppa_ctrl.sv -----
// Controller state machine that sequences one operation through the datapath.
module hppa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hppa_pkg::ctl_sts_t  sts_i,
  output hppa_pkg::ctl_cmd_t  cmd_o
);
  import hppa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_ENCODE = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_MOD    = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.mod_phase = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = S_ENCODE;
      end
      S_ENCODE: begin
        cmd_o.encode = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.need_mod) begin
          cnt_d   = CNT_W'(MOD_STEPS - 1);
          state_d = S_MOD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_RESP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MATCH))
    else $error("Accepted transaction did not enter the match step.");

  a_exec_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (state_q == S_MOD || state_q == S_RESP))
    else $error("Execute step was not followed by modulo or response.");

  a_mod_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && cnt_q == '0) |=> (state_q == S_RESP))
    else $error("Modulo iteration did not finish after its last step.");

endmodule

// ----- hw/rtl/hppa_datapath.sv -----
// Datapath with frame table, ID match, free-frame encoder, data memory and bucket modulo unit.
module hppa_datapath #(
  parameter int unsigned MEMORY_WORDS = hppa_pkg::MEMORY_WORDS_DEF,
  parameter int unsigned PAGE_WORDS   = hppa_pkg::PAGE_WORDS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hppa_pkg::ctl_cmd_t  cmd_i,
  output hppa_pkg::ctl_sts_t  sts_o,
  input  logic [2:0]          in_operation_i,
  input  logic [31:0]         in_pid_i,
  input  logic [31:0]         in_offset_i,
  input  logic signed [31:0]  in_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_status_o,
  output logic [5:0]          out_bucket_o,
  output logic [31:0]         out_offset_echo_o,
  output logic signed [31:0]  out_read_value_o
);
  import hppa_pkg::*;

  localparam int unsigned FRAMES     = MEMORY_WORDS / PAGE_WORDS;
  localparam bit          HAS_FRAMES = (FRAMES != 0);
  localparam int unsigned FRAMES_EFF = (FRAMES == 0) ? 1 : FRAMES;
  localparam int unsigned FIW        = (FRAMES_EFF > 1) ? $clog2(FRAMES_EFF) : 1;
  localparam int unsigned AW         = $clog2(MEMORY_WORDS);

  // The bucket quotient is pid times a rounded-up reciprocal, shifted right.
  localparam int unsigned     MOD_L   = (FRAMES_EFF > 1) ? $clog2(FRAMES_EFF) : 0;
  localparam longint unsigned MOD_M   = ((64'd1 << (32 + MOD_L)) + 64'(FRAMES_EFF) - 64'd1)
                                        / 64'(FRAMES_EFF);
  localparam logic [32:0]     MOD_M_V = 33'(MOD_M);

  logic [2:0]         op_q;
  logic [31:0]        pid_q;
  logic [31:0]        off_q;
  logic signed [31:0] val_q;

  logic [FRAMES_EFF-1:0] used_q;
  logic [31:0]           owner_q [FRAMES_EFF];
  logic signed [31:0]    data_mem_q [MEMORY_WORDS];

  logic [FRAMES_EFF-1:0] match_d, match_q, free_d, free_q;
  logic                  in_page_q;
  logic                  found_d, found_q, free_any_d, free_any_q;
  logic [FIW-1:0]        hit_idx_d, hit_idx_q, free_idx_d, free_idx_q;

  logic               pid_nz, ins_ok, srch_ok, acc_ok, del_ok;
  logic [AW-1:0]      addr;
  logic               status_q, srch_ok_q, rd_ok_q;
  logic signed [31:0] rdata_q;

  logic [64:0] mod_prod;
  logic [31:0] quot_d, quot_q;
  logic [5:0]  rem_d, rem_q;

  logic               out_valid_q;
  logic               out_status_q;
  logic [5:0]         out_bucket_q;
  logic [31:0]        out_echo_q;
  logic signed [31:0] out_rval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_operation_i;
      pid_q <= in_pid_i;
      off_q <= in_offset_i;
      val_q <= in_value_i;
    end
  end

  always_comb begin
    for (int i = 0; i < int'(FRAMES_EFF); i++) begin
      match_d[i] = HAS_FRAMES && used_q[i] && (owner_q[i] == pid_q);
      free_d[i]  = HAS_FRAMES && !used_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) begin
      match_q   <= match_d;
      free_q    <= free_d;
      in_page_q <= (off_q < 32'(PAGE_WORDS));
    end
  end

  always_comb begin
    found_d    = |match_q;
    free_any_d = |free_q;
    hit_idx_d  = '0;
    free_idx_d = '0;
    for (int i = int'(FRAMES_EFF) - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx_d = FIW'(i);
      end
      if (free_q[i]) begin
        free_idx_d = FIW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.encode) begin
      found_q    <= found_d;
      free_any_q <= free_any_d;
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
    end
  end

  always_comb begin
    pid_nz  = (pid_q != '0);
    ins_ok  = 1'b0;
    srch_ok = 1'b0;
    acc_ok  = 1'b0;
    del_ok  = 1'b0;
    unique case (op_q)
      OP_INSERT: ins_ok  = !found_q && free_any_q;
      OP_SEARCH: srch_ok = found_q && pid_nz;
      OP_WRITE,
      OP_READ:   acc_ok  = found_q && pid_nz && in_page_q;
      OP_DELETE: del_ok  = found_q;
      default: begin
      end
    endcase
    addr = AW'(AW'(hit_idx_q) * AW'(PAGE_WORDS)) + AW'(off_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.exec && ins_ok) begin
      used_q[free_idx_q] <= 1'b1;
    end else if (cmd_i.exec && del_ok) begin
      used_q[hit_idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && ins_ok) begin
      owner_q[free_idx_q] <= pid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && acc_ok) begin
      if (op_q == OP_WRITE) begin
        data_mem_q[addr] <= val_q;
      end else begin
        rdata_q <= data_mem_q[addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q  <= !(ins_ok || srch_ok || acc_ok || del_ok);
      srch_ok_q <= srch_ok;
      rd_ok_q   <= acc_ok && (op_q == OP_READ);
    end
  end

  always_comb begin
    mod_prod = 65'(pid_q) * 65'(MOD_M_V);
    quot_d   = 32'(mod_prod >> (32 + MOD_L));
    rem_d    = 6'(pid_q - quot_q * 32'(FRAMES_EFF));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_step) begin
      if (cmd_i.mod_phase != '0) begin
        quot_q <= quot_d;
      end else begin
        rem_q <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      out_status_q <= status_q;
      out_bucket_q <= srch_ok_q ? rem_q : 6'b0;
      out_echo_q   <= rd_ok_q ? off_q : 32'b0;
      out_rval_q   <= rd_ok_q ? rdata_q : 32'sb0;
    end
  end

  assign sts_o.need_mod = srch_ok;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_bucket_o      = out_bucket_q;
  assign out_offset_echo_o = out_echo_q;
  assign out_read_value_o  = out_rval_q;

endmodule

// ----- hw/rtl/hashed_process_page_allocator.sv -----
// Top level of the hashed process page allocator.
// The block hands out fixed-size pages of a word memory to processes, one page each.
// A request transaction on item_i carries an operation (insert, search, write, read,
// delete), a process ID, a word offset and a write value. Every request produces
// exactly one response transaction on result_o with a status, the hash bucket of a
// successful search, and the offset and data word of a successful read.
// A request is taken only while the controller is idle. It then passes through a match
// step that compares the ID against all frame owners, an encode step that
// priority-encodes the hit and the lowest free frame, and an execute step that updates
// the frame table or accesses the data memory; the response register loads after that.
// A new request is accepted only once the previous one has loaded its response. A
// successful search also runs the modulo unit before the response, which forms the
// bucket by a reciprocal multiplication and a subtraction.
// When the receiver stalls, a finished response waits in the output register; a new
// request can be accepted meanwhile and its result waits in the response step until
// the register is free.
// Reset empties the frame table at once; the data memory is not cleared.
module hashed_process_page_allocator #(
  parameter int unsigned MEMORY_WORDS = hppa_pkg::MEMORY_WORDS_DEF,
  parameter int unsigned PAGE_WORDS   = hppa_pkg::PAGE_WORDS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  hppa_in_if.sink    item_i,
  hppa_out_if.source result_o
);
  import hppa_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  hppa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hppa_datapath #(
    .MEMORY_WORDS (MEMORY_WORDS),
    .PAGE_WORDS   (PAGE_WORDS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_operation_i    (item_i.operation),
    .in_pid_i          (item_i.pid),
    .in_offset_i       (item_i.offset),
    .in_value_i        (item_i.value),
    .out_valid_o       (result_o.valid),
    .out_ready_i       (result_o.ready),
    .out_status_o      (result_o.status),
    .out_bucket_o      (result_o.bucket),
    .out_offset_echo_o (result_o.offset_echo),
    .out_read_value_o  (result_o.read_value)
  );

endmodule
